FILE: rtl/pps_pkg.sv
// pps_pkg: shared types and constants of the preemptive priority scheduler
// holds the cell interface structs, the controller state enum and field widths
// depends on nothing
`timescale 1ns / 1ps

package pps_pkg;

	localparam int TASKS_DEF = 16;
	localparam int TIME_W    = 16;
	localparam int URG_W     = 8;
	localparam int SLOT_W    = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// candidate that travels down the chain during a scan
	typedef struct packed {
		logic              found;
		logic [URG_W-1:0]  urgency;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] left;
	} cand_t;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic              load;
		logic              run;
		logic              finish;
		logic [SLOT_W-1:0] load_slot;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [URG_W-1:0]  urgency;
	} cmd_t;

	// result fields of one transaction, all_done excluded
	typedef struct packed {
		logic              idle;
		logic [SLOT_W-1:0] run_slot;
		logic [TIME_W-1:0] tick_time;
		logic              finished;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] wait_time;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/pps_cell.sv
// pps_cell: one task slot of the scheduler chain
// stores one task and passes the best candidate so far to its neighbor
// depends on pps_pkg
`timescale 1ns / 1ps

module pps_cell import pps_pkg::*; #(
	parameter int TASKS = TASKS_DEF,
	parameter int INDEX = 0,
	localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [IW-1:0]     run_slot,
	input  logic [TIME_W-1:0] now,
	input  logic              tok_in,
	input  cand_t             cand_in,
	input  logic [IW-1:0]     slot_in,
	output logic              tok_out,
	output cand_t             cand_out,
	output logic [IW-1:0]     slot_out,
	output logic              pending
);

	logic [TIME_W-1:0] arrival_q;
	logic [TIME_W-1:0] burst_q;
	logic [TIME_W-1:0] left_q;
	logic [URG_W-1:0]  urgency_q;
	logic              valid_q;
	logic              done_q;
	logic              tok_q;
	cand_t             cand_q;
	logic [IW-1:0]     slot_q;

	logic load_hit;
	logic run_hit;
	logic eligible;
	logic take;

	assign load_hit = cmd.load && (32'(cmd.load_slot) == 32'(INDEX));
	assign run_hit  = cmd.run && (run_slot == IW'(INDEX));

	// this slot beats the incoming candidate
	assign eligible = valid_q && !done_q && (arrival_q <= now);
	assign take     = eligible && (!cand_in.found || (urgency_q < cand_in.urgency));

	// task marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (load_hit) begin
				valid_q <= 1'b1;
				done_q  <= (cmd.burst == '0);
			end else if (run_hit && cmd.finish) begin
				done_q <= 1'b1;
			end
		end
	end

	// task fields
	always_ff @(posedge clk) begin
		if (load_hit) begin
			arrival_q <= cmd.arrival;
			burst_q   <= cmd.burst;
			left_q    <= cmd.burst;
			urgency_q <= cmd.urgency;
		end else if (run_hit) begin
			left_q <= left_q - TIME_W'(1);
		end
	end

	// candidate hand-off to the next cell
	always_ff @(posedge clk) begin
		if (take) begin
			cand_q.found   <= 1'b1;
			cand_q.urgency <= urgency_q;
			cand_q.arrival <= arrival_q;
			cand_q.burst   <= burst_q;
			cand_q.left    <= left_q;
			slot_q         <= IW'(INDEX);
		end else begin
			cand_q <= cand_in;
			slot_q <= slot_in;
		end
	end

	assign tok_out  = tok_q;
	assign cand_out = cand_q;
	assign slot_out = slot_q;
	assign pending  = valid_q && !done_q;

endmodule

FILE: rtl/preemptive_priority_scheduler.sv
// preemptive_priority_scheduler: top level, controller and chain of task cells
// depends on pps_pkg and pps_cell
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_ready    kind slot arrival burst urgency
//   output   out        out_valid / out_ready  idle run_slot tick_time finished
//                                              finish_time turnaround wait_time all_done
//
// a load transaction goes from idle straight to the final state; a tick also passes
// through the scan state while the candidate walks the chain one cell per cycle
// one transaction is in work at a time; in_ready is high whenever the controller
// is idle, even while a result waits in the output register
// a stalled output holds the controller in its final state until the register frees
// arst_n clears the time counter, all task marks and both handshake sides
`timescale 1ns / 1ps

module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int TASKS = TASKS_DEF,
	localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [SLOT_W-1:0] slot,
	input  logic [TIME_W-1:0] arrival,
	input  logic [TIME_W-1:0] burst,
	input  logic [URG_W-1:0]  urgency,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              idle,
	output logic [SLOT_W-1:0] run_slot,
	output logic [TIME_W-1:0] tick_time,
	output logic              finished,
	output logic [TIME_W-1:0] finish_time,
	output logic [TIME_W-1:0] turnaround,
	output logic [TIME_W-1:0] wait_time,
	output logic              all_done
);

	state_t            state_q, state_d;
	logic [TIME_W-1:0] now_q;
	res_t              res_q, res_d;
	res_t              out_q;
	logic              out_valid_q;
	logic              out_all_done_q;

	cmd_t              cmd;
	logic              start;
	logic              res_we;
	logic              now_we;
	logic              out_load;

	logic              tok_chain  [TASKS+1];
	cand_t             cand_chain [TASKS+1];
	logic [IW-1:0]     slot_chain [TASKS+1];
	logic [TASKS-1:0]  pending;

	cand_t             best;
	logic [IW-1:0]     best_slot;
	logic [TIME_W-1:0] left_new;
	logic              fin;
	logic [TIME_W-1:0] now_next;
	logic [TIME_W-1:0] tat;
	logic [TIME_W-1:0] wt;
	res_t              tick_res;
	res_t              load_res;

	// chain head: empty candidate, token on a tick start
	assign tok_chain[0]  = start;
	assign cand_chain[0] = '0;
	assign slot_chain[0] = '0;

	for (genvar i = 0; i < TASKS; i++) begin : g_cell
		pps_cell #(
			.TASKS (TASKS),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.run_slot (best_slot),
			.now      (now_q),
			.tok_in   (tok_chain[i]),
			.cand_in  (cand_chain[i]),
			.slot_in  (slot_chain[i]),
			.tok_out  (tok_chain[i+1]),
			.cand_out (cand_chain[i+1]),
			.slot_out (slot_chain[i+1]),
			.pending  (pending[i])
		);
	end

	assign best      = cand_chain[TASKS];
	assign best_slot = slot_chain[TASKS];

	// tick arithmetic on the winning candidate
	always_comb begin
		left_new = best.left - TIME_W'(1);
		fin      = best.found && (left_new == '0);
		now_next = (now_q == TIME_MAX) ? now_q : now_q + TIME_W'(1);
		tat      = now_next - best.arrival;
		wt       = (tat >= best.burst) ? tat - best.burst : '0;

		tick_res.idle        = !best.found;
		tick_res.run_slot    = best.found ? SLOT_W'(best_slot) : '0;
		tick_res.tick_time   = now_q;
		tick_res.finished    = fin;
		tick_res.finish_time = fin ? now_next : '0;
		tick_res.turnaround  = fin ? tat : '0;
		tick_res.wait_time   = fin ? wt : '0;

		load_res      = '0;
		load_res.idle = 1'b1;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		start         = 1'b0;
		res_we        = 1'b0;
		res_d         = load_res;
		now_we        = 1'b0;
		out_load      = 1'b0;
		cmd.load      = 1'b0;
		cmd.run       = 1'b0;
		cmd.finish    = fin;
		cmd.load_slot = slot;
		cmd.arrival   = arrival;
		cmd.burst     = burst;
		cmd.urgency   = urgency;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_LOAD) begin
						cmd.load = 1'b1;
						res_we   = 1'b1;
						state_d  = ST_DONE;
					end else begin
						start   = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (tok_chain[TASKS]) begin
					now_we  = 1'b1;
					res_we  = 1'b1;
					res_d   = tick_res;
					cmd.run = best.found;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// time counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (now_we) begin
			now_q <= now_next;
		end
	end

	// result held until the output register frees
	always_ff @(posedge clk) begin
		if (res_we) begin
			res_q <= res_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q          <= res_q;
			out_all_done_q <= ~|pending;
		end
	end

	assign out_valid   = out_valid_q;
	assign idle        = out_q.idle;
	assign run_slot    = out_q.run_slot;
	assign tick_time   = out_q.tick_time;
	assign finished    = out_q.finished;
	assign finish_time = out_q.finish_time;
	assign turnaround  = out_q.turnaround;
	assign wait_time   = out_q.wait_time;
	assign all_done    = out_all_done_q;

endmodule
